### rtl/mrp_pkg.sv
// ============================================================================
// mrp_pkg - shared types and constants of the mesh relay path rewriter
// Queue entry layout, register indexes, default limits and hop id byte select.
// ============================================================================
`default_nettype none

package mrp_pkg;

   localparam int DEF_PATH_LIMIT   = 64;
   localparam int DEF_PACKET_LIMIT = 255;

   // entries of the queue between front and back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_RELAY_ENABLE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_HOP_ID   = 1'd1;

   // route_kind codes
   localparam logic [1:0] RK_FLOOD            = 2'd0;
   localparam logic [1:0] RK_TRANSPORT_FLOOD  = 2'd1;
   localparam logic [1:0] RK_DIRECT           = 2'd2;
   localparam logic [1:0] RK_TRANSPORT_DIRECT = 2'd3;

   localparam logic [5:0] HOP_COUNT_MAX = 6'h3F;

   // one unit of work for the back end: a byte followed by 0..4 hop id bytes,
   // or a drop marker
   typedef struct packed {
      logic [7:0] first_byte;
      logic [2:0] extra;
      logic       last;
      logic       drop;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [7:0] own_byte(input logic [31:0] id, input logic [1:0] sel);
      logic [7:0] result;
      case (sel)
         2'd0:    result = id[7:0];
         2'd1:    result = id[15:8];
         2'd2:    result = id[23:16];
         default: result = id[31:24];
      endcase
      return result;
   endfunction

endpackage

`default_nettype wire

### rtl/mrp_intf.sv
// ============================================================================
// mrp_intf - channel interfaces of the mesh relay path rewriter
// Packet byte input, rewritten byte output and register write channel.
// ============================================================================
`default_nettype none

interface mrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_packet;
   logic [1:0] route_kind;

   modport source (output valid, data_byte, end_of_packet, route_kind, input ready);
   modport sink   (input valid, data_byte, end_of_packet, route_kind, output ready);
endinterface

interface mrp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_byte;
   logic       out_last;
   logic       drop;

   modport source (output valid, out_byte, has_byte, out_last, drop, input ready);
   modport sink   (input valid, out_byte, has_byte, out_last, drop, output ready);
endinterface

interface mrp_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/mesh_relay_path_rewriter.sv
// ============================================================================
// mesh_relay_path_rewriter - relayed form of a received mesh packet
// Byte stream in, rewritten byte stream out: path length rewrite, own hop
// append on flood routes, own hop check and strip on direct routes.
// ============================================================================
//
//  channel  dir  transaction carries
//  req      in   data_byte, end_of_packet, route_kind (one packet byte)
//  rsp      out  out_byte, has_byte, out_last, drop (one result)
//  csr      in   index, data (0 relay_enable, 1 own_hop_id); always ready
//
//  One input byte is accepted per cycle while the job queue has room.
//  A byte emits its results one per cycle from the back end, unless rsp
//  stalls; bytes that append this node's hop give 1 + hop size, others one.
//  The four-entry job queue absorbs those bursts; output is a register slot.
//  Synchronous active-high reset clears parser state, queue and output valid.
//
`default_nettype none

module mesh_relay_path_rewriter
   import mrp_pkg::*;
#(
   parameter int PATH_LIMIT   = DEF_PATH_LIMIT,
   parameter int PACKET_LIMIT = DEF_PACKET_LIMIT
) (
   input  wire logic clock,
   input  wire logic reset,
   mrp_req_if.sink   req,
   mrp_rsp_if.source rsp,
   mrp_csr_if.sink   csr
);

   logic             relay_enable_ff;
   logic [31:0]      own_hop_id_ff;

   logic             push;
   logic             pop;
   job_type          push_job;
   job_type          head_job;
   queue_status_type q_status;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         relay_enable_ff <= 1'b0;
         own_hop_id_ff   <= 32'd0;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_RELAY_ENABLE: relay_enable_ff <= csr.data[0];
            CSR_OWN_HOP_ID:   own_hop_id_ff   <= csr.data;
            default:          ;
         endcase
      end
   end

   mrp_front #(
      .PATH_LIMIT   (PATH_LIMIT),
      .PACKET_LIMIT (PACKET_LIMIT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .relay_enable (relay_enable_ff),
      .own_hop_id   (own_hop_id_ff),
      .q_status     (q_status),
      .push         (push),
      .push_job     (push_job)
   );

   mrp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   mrp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .q_status   (q_status),
      .own_hop_id (own_hop_id_ff),
      .pop        (pop),
      .rsp        (rsp)
   );

endmodule

`default_nettype wire

### rtl/mrp_front.sv
// ============================================================================
// mrp_front - packet parser and classifier
// Tracks packet phase per byte, checks and rewrites the path length, decides
// rejection, pushes one job per byte that yields results or ends the packet.
// ============================================================================
`default_nettype none

module mrp_front
   import mrp_pkg::*;
#(
   parameter int PATH_LIMIT   = DEF_PATH_LIMIT,
   parameter int PACKET_LIMIT = DEF_PACKET_LIMIT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   mrp_req_if.sink               req,
   input  wire logic             relay_enable,
   input  wire logic [31:0]      own_hop_id,
   input  wire queue_status_type q_status,
   output      logic             push,
   output      job_type          push_job
);

   localparam int CNT_W = $clog2(PACKET_LIMIT + 1);
   localparam int SUM_W = CNT_W + 1;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_TRANSPORT,
      PH_PATHLEN,
      PH_PATH,
      PH_PAYLOAD
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [1:0]       route_ff, route_in;
   logic [2:0]       hop_size_ff, hop_size_in;
   logic [7:0]       left_ff, left_in;
   logic [2:0]       bip_ff, bip_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             swallow_ff, swallow_in;

   logic             accept;
   logic             has_first;
   logic [7:0]       first_byte;
   logic [2:0]       extra;
   logic             reject;
   logic [2:0]       n_results;
   logic [SUM_W-1:0] count_sum;
   logic [5:0]       cnt;
   logic [6:0]       cnt_p1;
   logic [2:0]       hs_new;
   logic [8:0]       flood_len;
   logic [7:0]       left_dec;
   logic             direct_route;
   logic             marker;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && !q_status.full;

   assign cnt          = req.data_byte[5:0];
   assign cnt_p1       = {1'b0, cnt} + 7'd1;
   assign hs_new       = {1'b0, req.data_byte[7:6]} + 3'd1;
   assign flood_len    = {2'b00, cnt_p1} * {6'b0, hs_new};
   assign left_dec     = left_ff - 8'd1;
   assign direct_route = route_ff[1];

   always_comb begin
      phase_in    = phase_ff;
      route_in    = route_ff;
      hop_size_in = hop_size_ff;
      left_in     = left_ff;
      bip_in      = bip_ff;
      count_in    = count_ff;
      swallow_in  = swallow_ff;
      has_first   = 1'b0;
      first_byte  = req.data_byte;
      extra       = 3'd0;
      reject      = 1'b0;

      if (!swallow_ff) begin
         case (phase_ff)
            PH_HEADER: begin
               route_in = req.route_kind;
               if (!relay_enable) begin
                  reject = 1'b1;
               end else begin
                  has_first = 1'b1;
                  bip_in    = 3'd0;
                  phase_in  = req.route_kind[0] ? PH_TRANSPORT : PH_PATHLEN;
               end
            end
            PH_TRANSPORT: begin
               has_first = 1'b1;
               bip_in    = bip_ff + 3'd1;
               if (bip_ff + 3'd1 >= 3'd4) begin
                  bip_in   = 3'd0;
                  phase_in = PH_PATHLEN;
               end
            end
            PH_PATHLEN: begin
               hop_size_in = hs_new;
               left_in     = 8'({2'b00, cnt} * {5'b0, hs_new});
               bip_in      = 3'd0;
               if (!direct_route) begin
                  if (cnt == HOP_COUNT_MAX || flood_len > 9'(PATH_LIMIT)) begin
                     reject = 1'b1;
                  end else begin
                     has_first  = 1'b1;
                     first_byte = {req.data_byte[7:6], cnt_p1[5:0]};
                     if (cnt == 6'd0) begin
                        extra    = hs_new;
                        phase_in = PH_PAYLOAD;
                     end else begin
                        phase_in = PH_PATH;
                     end
                  end
               end else begin
                  if (cnt == 6'd0) begin
                     reject = 1'b1;
                  end else begin
                     has_first  = 1'b1;
                     first_byte = {req.data_byte[7:6], cnt - 6'd1};
                     phase_in   = PH_PATH;
                  end
               end
            end
            PH_PATH: begin
               left_in = left_dec;
               if (!direct_route) begin
                  has_first = 1'b1;
                  if (left_dec == 8'd0) begin
                     extra    = hop_size_ff;
                     phase_in = PH_PAYLOAD;
                  end
               end else begin
                  // leading hop must be ours; it is stripped
                  if (bip_ff < hop_size_ff) begin
                     if (req.data_byte != own_byte(own_hop_id, bip_ff[1:0])) begin
                        reject = 1'b1;
                     end
                     bip_in = bip_ff + 3'd1;
                  end else begin
                     has_first = 1'b1;
                  end
                  if (left_dec == 8'd0) begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            default: begin
               has_first = 1'b1;
            end
         endcase
      end

      n_results = {2'b00, has_first} + extra;
      count_sum = {1'b0, count_ff} + SUM_W'(n_results);
      if (!swallow_ff && !reject && count_sum > SUM_W'(PACKET_LIMIT)) begin
         reject = 1'b1;
      end
      if (reject) begin
         swallow_in = 1'b1;
         n_results  = 3'd0;
      end else if (!swallow_ff) begin
         count_in = count_sum[CNT_W-1:0];
      end

      marker = swallow_in || (phase_in != PH_PAYLOAD) || (n_results == 3'd0);

      push                = 1'b0;
      push_job.first_byte = first_byte;
      push_job.extra      = extra;
      push_job.last       = 1'b0;
      push_job.drop       = 1'b0;
      if (req.end_of_packet) begin
         push = accept;
         if (marker) begin
            push_job.first_byte = 8'd0;
            push_job.extra      = 3'd0;
            push_job.drop       = 1'b1;
         end
         push_job.last = 1'b1;
      end else begin
         push = accept && (n_results != 3'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         route_ff    <= RK_FLOOD;
         hop_size_ff <= 3'd1;
         left_ff     <= 8'd0;
         bip_ff      <= 3'd0;
         count_ff    <= '0;
         swallow_ff  <= 1'b0;
      end else if (accept) begin
         if (req.end_of_packet) begin
            phase_ff    <= PH_HEADER;
            route_ff    <= RK_FLOOD;
            hop_size_ff <= 3'd1;
            left_ff     <= 8'd0;
            bip_ff      <= 3'd0;
            count_ff    <= '0;
            swallow_ff  <= 1'b0;
         end else begin
            phase_ff    <= phase_in;
            route_ff    <= route_in;
            hop_size_ff <= hop_size_in;
            left_ff     <= left_in;
            bip_ff      <= bip_in;
            count_ff    <= count_in;
            swallow_ff  <= swallow_in;
         end
      end
   end

endmodule

`default_nettype wire

### rtl/mrp_queue.sv
// ============================================================================
// mrp_queue - job queue between front and back end
// Small register FIFO that lets the parser and the emitter stall apart.
// ============================================================================
`default_nettype none

module mrp_queue
   import mrp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire job_type    push_job,
   input  wire logic       pop,
   output      job_type    head_job,
   output queue_status_type status
);

   localparam logic [QUEUE_AW:0] DEPTH_VAL = (QUEUE_AW + 1)'(QUEUE_DEPTH);

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]   count_ff, count_in;

   assign status.full  = (count_ff == DEPTH_VAL);
   assign status.empty = (count_ff == '0);
   assign head_job     = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_AW + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_ff + QUEUE_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_ff + QUEUE_AW'(1);
         end
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push || pop)
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("job queue underflow");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_VAL)
      else $error("job queue count out of range");

endmodule

`default_nettype wire

### rtl/mrp_back.sv
// ============================================================================
// mrp_back - result emitter
// Expands each job into its output transactions: the byte itself, then any
// appended hop id bytes, or a single drop marker. Output is registered.
// ============================================================================
`default_nettype none

module mrp_back
   import mrp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire job_type          head_job,
   input  wire queue_status_type q_status,
   input  wire logic [31:0]      own_hop_id,
   output      logic             pop,
   mrp_rsp_if.source             rsp
);

   logic       rsp_valid_ff;
   logic [7:0] out_byte_ff;
   logic       has_byte_ff;
   logic       out_last_ff;
   logic       drop_ff;

   logic       busy_ff;
   logic [1:0] idx_ff;
   logic [2:0] extra_ff;
   logic       last_ff;

   logic       slot_free;
   logic       final_hop;

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign pop       = slot_free && !busy_ff && !q_status.empty;
   assign final_hop = ({1'b0, idx_ff} + 3'd1) == extra_ff;

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_byte = out_byte_ff;
   assign rsp.has_byte = has_byte_ff;
   assign rsp.out_last = out_last_ff;
   assign rsp.drop     = drop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         busy_ff      <= 1'b0;
         idx_ff       <= 2'd0;
      end else if (slot_free) begin
         if (busy_ff) begin
            // appended hop id bytes
            rsp_valid_ff <= 1'b1;
            out_byte_ff  <= own_byte(own_hop_id, idx_ff);
            has_byte_ff  <= 1'b1;
            out_last_ff  <= last_ff && final_hop;
            drop_ff      <= 1'b0;
            idx_ff       <= idx_ff + 2'd1;
            if (final_hop) begin
               busy_ff <= 1'b0;
            end
         end else if (!q_status.empty) begin
            rsp_valid_ff <= 1'b1;
            out_byte_ff  <= head_job.first_byte;
            has_byte_ff  <= !head_job.drop;
            out_last_ff  <= head_job.last && (head_job.extra == 3'd0);
            drop_ff      <= head_job.drop;
            extra_ff     <= head_job.extra;
            last_ff      <= head_job.last;
            idx_ff       <= 2'd0;
            busy_ff      <= (head_job.extra != 3'd0);
         end else begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   a_busy_has_hops: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> extra_ff != 3'd0 && {1'b0, idx_ff} < extra_ff)
      else $error("hop expansion index out of range");

   a_busy_output_held: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rsp_valid_ff)
      else $error("hop expansion without a pending output");

   a_marker_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && drop_ff |-> out_last_ff && !has_byte_ff && !busy_ff)
      else $error("malformed drop marker");

endmodule

`default_nettype wire
